@@ src/sls_pkg.sv @@
// Shared types, constants and codes for the sorted list store.
`timescale 1ns / 1ps
`default_nettype none
package sls_pkg;

	// Field widths
	localparam int VAL_W   = 32;
	localparam int POS_W   = 5;
	localparam int KIND_W  = 2;
	localparam int TOTAL_W = 6;
	localparam int ST_W    = 2;

	// Default number of entries
	localparam int CAPACITY_DEF = 32;

	// Value returned by a get past the end
	localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;

	// Request kinds
	localparam logic [KIND_W-1:0] REQ_INSERT   = 2'd0;
	localparam logic [KIND_W-1:0] REQ_REMOVE   = 2'd1;
	localparam logic [KIND_W-1:0] REQ_CONTAINS = 2'd2;
	localparam logic [KIND_W-1:0] REQ_GET      = 2'd3;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// Read address select
	localparam logic [1:0] RD_IDX    = 2'd0;
	localparam logic [1:0] RD_IDX_M1 = 2'd1;
	localparam logic [1:0] RD_IDX_P1 = 2'd2;
	localparam logic [1:0] RD_POS    = 2'd3;

	// Write data select
	localparam logic WR_VAL = 1'b0;
	localparam logic WR_RD  = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_req;
		logic       decide;
		logic       idx_dec;
		logic       idx_inc;
		logic       mem_rd;
		logic [1:0] rd_sel;
		logic       mem_wr;
		logic       wr_sel;
		logic       count_inc;
		logic       count_dec;
		logic       found_chk;
		logic       get_capture;
		logic       out_load;
	} sls_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              full;
		logic              pos_bad;
		logic              idx_zero;
		logic              rem_last;
		logic              scan_end;
		logic              key_gt;
		logic              out_free;
	} sls_stat_t;

endpackage
`default_nettype wire

@@ src/sls_req_if.sv @@
// Request channel interface of the sorted list store.
`timescale 1ns / 1ps
`default_nettype none
interface sls_req_if
	import sls_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        req_type;
	logic signed [VAL_W-1:0]  operand_value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output req_type, output operand_value, output position,
		input ready);
	modport sink (input valid, input req_type, input operand_value, input position,
		output ready);
endinterface
`default_nettype wire

@@ src/sls_rsp_if.sv @@
// Result channel interface of the sorted list store.
`timescale 1ns / 1ps
`default_nettype none
interface sls_rsp_if
	import sls_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [VAL_W-1:0]  result_value;
	logic                     found;
	logic [TOTAL_W-1:0]       entry_total;
	logic [ST_W-1:0]          status;

	modport source (output valid, output result_value, output found, output entry_total,
		output status, input ready);
	modport sink (input valid, input result_value, input found, input entry_total,
		input status, output ready);
endinterface
`default_nettype wire

@@ src/sls_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ src/sls_ctrl.sv @@
// Controller state machine: sequences the memory walks of each request.
`timescale 1ns / 1ps
`default_nettype none
module sls_ctrl
	import sls_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire sls_stat_t stat,
	output sls_cmd_t       cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECIDE   = 4'd1;
	localparam logic [3:0] S_INS_CHK  = 4'd2;
	localparam logic [3:0] S_INS_CMP  = 4'd3;
	localparam logic [3:0] S_REM_CHK  = 4'd4;
	localparam logic [3:0] S_REM_MOV  = 4'd5;
	localparam logic [3:0] S_CON_CHK  = 4'd6;
	localparam logic [3:0] S_CON_CMP  = 4'd7;
	localparam logic [3:0] S_GET_WAIT = 4'd8;
	localparam logic [3:0] S_FINISH   = 4'd9;

	logic [3:0] state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				unique case (stat.kind)
					REQ_INSERT:   state_d = stat.full ? S_FINISH : S_INS_CHK;
					REQ_REMOVE:   state_d = stat.pos_bad ? S_FINISH : S_REM_CHK;
					REQ_CONTAINS: state_d = S_CON_CHK;
					REQ_GET: begin
						if (stat.pos_bad) begin
							state_d = S_FINISH;
						end else begin
							cmd.mem_rd = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_GET_WAIT;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			// Walk down from the end, moving larger entries up one slot
			S_INS_CHK: begin
				if (stat.idx_zero) begin
					cmd.mem_wr    = 1'b1;
					cmd.wr_sel    = WR_VAL;
					cmd.count_inc = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = RD_IDX_M1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				cmd.mem_wr = 1'b1;
				if (stat.key_gt) begin
					cmd.wr_sel  = WR_RD;
					cmd.idx_dec = 1'b1;
					state_d     = S_INS_CHK;
				end else begin
					cmd.wr_sel    = WR_VAL;
					cmd.count_inc = 1'b1;
					state_d       = S_FINISH;
				end
			end
			// Close the gap, moving later entries down one slot
			S_REM_CHK: begin
				if (stat.rem_last) begin
					cmd.count_dec = 1'b1;
					state_d       = S_FINISH;
				end else begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = RD_IDX_P1;
					state_d    = S_REM_MOV;
				end
			end
			S_REM_MOV: begin
				cmd.mem_wr  = 1'b1;
				cmd.wr_sel  = WR_RD;
				cmd.idx_inc = 1'b1;
				state_d     = S_REM_CHK;
			end
			// Linear scan for a match
			S_CON_CHK: begin
				if (stat.scan_end) begin
					state_d = S_FINISH;
				end else begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_CON_CMP;
				end
			end
			S_CON_CMP: begin
				cmd.found_chk = 1'b1;
				cmd.idx_inc   = 1'b1;
				state_d       = S_CON_CHK;
			end
			S_GET_WAIT: begin
				cmd.get_capture = 1'b1;
				state_d         = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	// An accepted request always moves on to decoding
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid) |=> (state_q == S_DECIDE))
		else $error("accepted request not decoded");

	// A finished result leaves as soon as the output slot is free
	a_finish_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && stat.out_free) |=> (state_q == S_IDLE))
		else $error("finished request not handed to output");
`endif
endmodule
`default_nettype wire

@@ src/sls_dp.sv @@
// Datapath: request registers, entry memory, count, index and result registers.
`timescale 1ns / 1ps
`default_nettype none
module sls_dp
	import sls_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [KIND_W-1:0]  req_type,
	input  wire logic [VAL_W-1:0]   operand_value,
	input  wire logic [POS_W-1:0]   position,
	input  wire sls_cmd_t           cmd,
	output sls_stat_t               stat,
	input  wire logic               rsp_ready,
	output logic                    rsp_valid,
	output logic [VAL_W-1:0]        result_value,
	output logic                    found,
	output logic [TOTAL_W-1:0]      entry_total,
	output logic [ST_W-1:0]         status
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > POS_W) ? CW : POS_W;

	logic [KIND_W-1:0]  kind_q;
	logic [VAL_W-1:0]   val_q;
	logic [POS_W-1:0]   pos_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [VAL_W-1:0]   result_q;
	logic               found_q;
	logic [ST_W-1:0]    status_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   out_value_q;
	logic               out_found_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [ST_W-1:0]    out_status_q;

	logic [WW-1:0]      pos_ext, cnt_ext;
	logic [CW-1:0]      idx_m1, idx_p1;
	logic [AW-1:0]      ram_raddr;
	logic [VAL_W-1:0]   ram_wdata, ram_rdata;

	// Address arithmetic and status toward the controller
	always_comb begin
		pos_ext       = WW'(pos_q);
		cnt_ext       = WW'(count_q);
		idx_m1        = idx_q - CW'(1);
		idx_p1        = idx_q + CW'(1);
		stat.kind     = kind_q;
		stat.full     = (count_q == CW'(CAPACITY));
		stat.pos_bad  = (pos_ext >= cnt_ext);
		stat.idx_zero = (idx_q == '0);
		stat.rem_last = (idx_p1 >= count_q);
		stat.scan_end = (idx_q >= count_q);
		stat.key_gt   = ($signed(ram_rdata) > $signed(val_q));
		stat.out_free = !out_valid_q || rsp_ready;
	end

	// Memory read address and write data select
	always_comb begin
		unique case (cmd.rd_sel)
			RD_IDX:    ram_raddr = idx_q[AW-1:0];
			RD_IDX_M1: ram_raddr = idx_m1[AW-1:0];
			RD_IDX_P1: ram_raddr = idx_p1[AW-1:0];
			RD_POS:    ram_raddr = pos_ext[AW-1:0];
			default:   ram_raddr = idx_q[AW-1:0];
		endcase
		ram_wdata = (cmd.wr_sel == WR_RD) ? ram_rdata : val_q;
	end

	sls_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (cmd.mem_wr),
		.waddr (idx_q[AW-1:0]),
		.wdata (ram_wdata),
		.re    (cmd.mem_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Count, index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			priority if (cmd.decide) begin
				unique case (kind_q)
					REQ_INSERT: idx_q <= count_q;
					REQ_REMOVE: idx_q <= pos_ext[CW-1:0];
					default:    idx_q <= '0;
				endcase
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, working result and output payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q   <= req_type;
			val_q    <= operand_value;
			pos_q    <= position;
			result_q <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
		end
		if (cmd.decide) begin
			if (kind_q == REQ_INSERT && stat.full) begin
				status_q <= ST_FULL;
			end
			if (kind_q == REQ_REMOVE && stat.pos_bad) begin
				status_q <= ST_RANGE;
			end
			if (kind_q == REQ_GET && stat.pos_bad) begin
				result_q <= INT_MIN;
			end
		end
		if (cmd.found_chk && ram_rdata == val_q) begin
			found_q <= 1'b1;
		end
		if (cmd.get_capture) begin
			result_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			out_value_q  <= result_q;
			out_found_q  <= found_q;
			out_total_q  <= TOTAL_W'(count_q);
			out_status_q <= status_q;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign found        = out_found_q;
	assign entry_total  = out_total_q;
	assign status       = out_status_q;

`ifndef SYNTH
	// The count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// Memory writes stay inside the store
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (idx_q < CW'(CAPACITY)))
		else $error("memory write beyond capacity");

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("pending result overwritten");

	// A full report always comes with a full count
	a_full_total: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> (out_total_q == TOTAL_W'(CAPACITY)))
		else $error("full status with count below capacity");
`endif
endmodule
`default_nettype wire

@@ src/sorted_list_store.sv @@
// Each request is a memory walk sequenced by the controller: insert walks down from the end,
// moving larger entries up one slot; remove closes the gap by moving later entries down;
// contains scans every entry; get reads one entry; rejected requests skip the walk. One
// request at a time: the next is taken when the controller is back in idle, and the walk
// goes through the single read port. A finished result waits in an output reg.
// Reset (arst_n low, asynchronous) empties the store; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_store
	import sls_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sls_req_if.sink    req,
	sls_rsp_if.source  rsp
);
	sls_cmd_t  cmd;
	sls_stat_t stat;
	logic      req_ready;
	logic      rsp_valid;
	logic [VAL_W-1:0] result_value;

	sls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sls_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req.req_type),
		.operand_value (req.operand_value),
		.position      (req.position),
		.cmd           (cmd),
		.stat          (stat),
		.rsp_ready     (rsp.ready),
		.rsp_valid     (rsp_valid),
		.result_value  (result_value),
		.found         (rsp.found),
		.entry_total   (rsp.entry_total),
		.status        (rsp.status)
	);

	assign req.ready        = req_ready;
	assign rsp.valid        = rsp_valid;
	assign rsp.result_value = result_value;
endmodule
`default_nettype wire

@@ tb/sls_result_checker.sv @@
// Result checker for the sorted list store: tracks requests, predicts results, compares them.
`timescale 1ns / 1ps
module sls_result_checker
	import sls_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sls_req_if        req,
	sls_rsp_if        rsp,
	output int        mismatch_count,
	output int        pending_count
);

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic                    found;
		logic [TOTAL_W-1:0]      entry_total;
		logic [ST_W-1:0]         status;
	} sls_result_t;

	// Shadow copy of the store contents, kept in ascending signed order
	logic signed [VAL_W-1:0] shadow_vals [CAPACITY];
	int                      shadow_count = 0;

	// Results owed by the block, oldest first
	sls_result_t expected_results [$];

	initial begin
		mismatch_count = 0;
		pending_count  = 0;
	end

	// Apply one request to the shadow store and work out the result it yields
	function automatic sls_result_t apply_request(input logic [KIND_W-1:0] kind,
		input logic signed [VAL_W-1:0] value, input logic [POS_W-1:0] pos);
		sls_result_t r;
		int          slot;
		int          i;
		r = '0;
		case (kind)
			REQ_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					// new value goes after every entry equal to it
					slot = shadow_count;
					for (i = 0; i < shadow_count; i++)
						if (slot == shadow_count && shadow_vals[i] > value)
							slot = i;
					for (i = shadow_count; i > slot; i--)
						shadow_vals[i] = shadow_vals[i-1];
					shadow_vals[slot] = value;
					shadow_count++;
				end
			end
			REQ_REMOVE: begin
				if (int'(pos) >= shadow_count) begin
					r.status = ST_RANGE;
				end else begin
					for (i = int'(pos); i + 1 < shadow_count; i++)
						shadow_vals[i] = shadow_vals[i+1];
					shadow_count--;
				end
			end
			REQ_CONTAINS: begin
				for (i = 0; i < shadow_count; i++)
					if (shadow_vals[i] == value)
						r.found = 1'b1;
			end
			REQ_GET: begin
				// past the end reads as the most negative integer, status stays ok
				if (int'(pos) >= shadow_count)
					r.result_value = INT_MIN;
				else
					r.result_value = shadow_vals[pos];
			end
		endcase
		r.entry_total = TOTAL_W'(shadow_count);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		$error("%s mismatch: expected %0d, actual %0d", field, want, got);
		mismatch_count++;
	endtask

	// Watch both channels at the clock edge
	always @(posedge clk) begin
		sls_result_t want;
		if (arst_n) begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (rsp.result_value !== want.result_value)
						report_mismatch("result_value", want.result_value, rsp.result_value);
					if (rsp.found !== want.found)
						report_mismatch("found", want.found, rsp.found);
					if (rsp.entry_total !== want.entry_total)
						report_mismatch("entry_total", want.entry_total, rsp.entry_total);
					if (rsp.status !== want.status)
						report_mismatch("status", want.status, rsp.status);
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				expected_results.push_back(apply_request(req.req_type, req.operand_value,
					req.position));
			pending_count = expected_results.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
// Top of the sorted list store testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import sls_pkg::*;

	localparam int CLK_HALF_NS       = 6;
	localparam int CYCLE_LIMIT       = 1_000_000;
	localparam int ITEMS_PER_PHASE   = 500;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int SETTLE_CYCLES     = 100;

	// Mix of request kinds used by the random part
	typedef enum logic [1:0] {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} req_mix_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int long_stalls_asked  = 0;
	int cycle_count        = 0;
	int mismatch_count;
	int pending_count;

	sls_req_if req ();
	sls_rsp_if rsp ();

	sorted_list_store #(
		.CAPACITY(CAPACITY_DEF)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	sls_result_checker #(
		.CAPACITY(CAPACITY_DEF)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	always begin
		#(CLK_HALF_NS) clk = 1'b1;
		#(CLK_HALF_NS) clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls, plus long hold-offs on request
	initial begin
		int served;
		int stall_pct_now;
		int n;
		served    = 0;
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			stall_pct_now = receiver_stall_pct;
			if (long_stalls_asked != served) begin
				served++;
				for (n = 0; n < LONG_STALL_CYCLES; n++) begin
					@(negedge clk);
					rsp.ready <= 1'b0;
				end
			end else begin
				@(negedge clk);
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct_now);
			end
		end
	end

	// Offer one request; entered and left at a falling edge
	task automatic send_request(input logic [KIND_W-1:0] kind,
		input logic signed [VAL_W-1:0] value, input logic [POS_W-1:0] pos);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid         <= 1'b1;
		req.req_type      <= kind;
		req.operand_value <= value;
		req.position      <= pos;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [KIND_W-1:0] pick_kind(input req_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  return (r < 70) ? REQ_INSERT : (r < 80) ? REQ_REMOVE :
				(r < 90) ? REQ_CONTAINS : REQ_GET;
			MIX_DRAIN: return (r < 10) ? REQ_INSERT : (r < 70) ? REQ_REMOVE :
				(r < 85) ? REQ_CONTAINS : REQ_GET;
			default:   return (r < 30) ? REQ_INSERT : (r < 55) ? REQ_REMOVE :
				(r < 80) ? REQ_CONTAINS : REQ_GET;
		endcase
	endfunction

	// Small values give duplicates and contains hits; extremes test signed order
	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $signed($urandom_range(0, 8)) - 4;
		if (r < 50) begin
			case ($urandom_range(0, 5))
				0: return INT_MIN;
				1: return INT_MIN + 1;
				2: return 32'sh7fff_ffff;
				3: return 32'sh7fff_fffe;
				4: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	// Mostly near the front, often near the top of the range
	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return POS_W'($urandom_range(0, 3));
		if (r < 70)
			return POS_W'($urandom_range(28, 31));
		return POS_W'($urandom_range(0, 31));
	endfunction

	// Main stimulus
	initial begin
		int phase;
		int item;
		req.valid         = 1'b0;
		req.req_type      = REQ_INSERT;
		req.operand_value = '0;
		req.position      = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty store: gets past the end, bad remove, contains miss
		send_request(REQ_GET, 0, 0);
		send_request(REQ_GET, 0, 31);
		send_request(REQ_REMOVE, 0, 0);
		send_request(REQ_CONTAINS, 0, 0);
		// Extremes and duplicates
		send_request(REQ_INSERT, 32'sh7fff_ffff, 0);
		send_request(REQ_INSERT, INT_MIN, 0);
		send_request(REQ_INSERT, 0, 0);
		send_request(REQ_INSERT, -1, 0);
		send_request(REQ_INSERT, 0, 0);
		send_request(REQ_INSERT, 32'sh7fff_ffff, 0);
		send_request(REQ_CONTAINS, INT_MIN, 0);
		send_request(REQ_CONTAINS, 32'sh7fff_ffff, 0);
		send_request(REQ_CONTAINS, 1, 0);
		send_request(REQ_GET, 0, 0);
		send_request(REQ_GET, 0, 5);
		send_request(REQ_GET, 0, 6);
		// Removes: past the end, last, first, middle
		send_request(REQ_REMOVE, 0, 6);
		send_request(REQ_REMOVE, 0, 5);
		send_request(REQ_REMOVE, 0, 0);
		send_request(REQ_REMOVE, 0, 1);
		send_request(REQ_GET, 0, 1);
		send_request(REQ_REMOVE, -1, 31);

		// Random requests over four idling phases
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
				default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
			endcase
			for (item = 0; item < ITEMS_PER_PHASE; item++) begin
				// long result hold-off while requests keep coming
				if ((phase == 0 || phase == 3) && item == 100)
					long_stalls_asked++;
				// let everything drain before going on
				if ((phase == 1 || phase == 2) && item == 250) begin
					req.valid <= 1'b0;
					@(negedge clk);
					while (pending_count != 0)
						@(negedge clk);
				end
				send_request(pick_kind(req_mix_t'((item / 50) % 3)), pick_value(),
					pick_position());
			end
		end
		req.valid <= 1'b0;

		// Wait for the last results, then let the bench settle before the verdict
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
